FILE: rtl/core/mkunr_pkg.sv
`default_nettype none
package mkunr_pkg;

   localparam int MacWidth   = 48;
   localparam int IpWidth    = 32;
   localparam int CsumWidth  = 16;
   localparam int ProtoWidth = 8;
   localparam int CsrIdxWidth = 2;

   localparam logic [ProtoWidth-1:0] UDP_PROTOCOL = 8'd17;

   localparam logic [CsrIdxWidth-1:0] CSR_ENTRY_ZERO_MAC    = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_ENTRY_ZERO_NEW_IP = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_ENTRY_ONE_MAC     = 2'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_ENTRY_ONE_NEW_IP  = 2'd3;

   localparam logic [MacWidth-1:0] ENTRY_ZERO_MAC_RESET    = 48'h0001_AF18_F697;
   localparam logic [IpWidth-1:0]  ENTRY_ZERO_NEW_IP_RESET = 32'hC0A8_64C9;
   localparam logic [MacWidth-1:0] ENTRY_ONE_MAC_RESET     = 48'h00C0_8B09_444D;
   localparam logic [IpWidth-1:0]  ENTRY_ONE_NEW_IP_RESET  = 32'hC0A8_64CA;

   localparam logic OP_INBOUND  = 1'b0;
   localparam logic OP_OUTBOUND = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_ADJUST
   } state_type;

   typedef struct packed {
      logic capture;
      logic lookup;
      logic load_out;
   } cmd_type;

endpackage
`default_nettype wire

FILE: rtl/core/mkunr_ctrl.sv
`default_nettype none
module mkunr_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output mkunr_pkg::cmd_type     cmd
);

   mkunr_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mkunr_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_stall    = 1'b1;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         mkunr_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = mkunr_pkg::ST_LOOKUP;
            end
         end
         mkunr_pkg::ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = mkunr_pkg::ST_ADJUST;
         end
         mkunr_pkg::ST_ADJUST: begin
            // wait until the output word is free or being taken
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = mkunr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mkunr_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

FILE: rtl/core/mkunr_dp.sv
`default_nettype none
module mkunr_dp (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire  mkunr_pkg::cmd_type                 cmd,
   input  wire                                      csr_write_enable,
   input  wire  [mkunr_pkg::CsrIdxWidth-1:0]        csr_index,
   input  wire  [mkunr_pkg::MacWidth-1:0]           csr_write_data,
   input  wire                                      req_operation,
   input  wire  [mkunr_pkg::MacWidth-1:0]           req_source_mac,
   input  wire  [mkunr_pkg::ProtoWidth-1:0]         req_protocol,
   input  wire  [mkunr_pkg::IpWidth-1:0]            req_src_ip,
   input  wire  [mkunr_pkg::IpWidth-1:0]            req_dst_ip,
   input  wire  [mkunr_pkg::CsumWidth-1:0]          req_ip_checksum,
   input  wire  [mkunr_pkg::CsumWidth-1:0]          req_udp_checksum,
   output logic                                     rsp_matched,
   output logic [mkunr_pkg::IpWidth-1:0]            rsp_src_ip_out,
   output logic [mkunr_pkg::IpWidth-1:0]            rsp_dst_ip_out,
   output logic [mkunr_pkg::CsumWidth-1:0]          rsp_ip_checksum_out,
   output logic [mkunr_pkg::CsumWidth-1:0]          rsp_udp_checksum_out,
   output logic                                     rsp_checksum_final
);

   localparam int IW = mkunr_pkg::IpWidth;
   localparam int CW = mkunr_pkg::CsumWidth;

   // incremental one's-complement update of a checksum for a 32-bit value change
   function automatic logic [CW-1:0] adjust(input logic [CW-1:0] hc,
                                            input logic [IW-1:0] old_v,
                                            input logic [IW-1:0] new_v);
      logic [CW+2:0] sum;
      logic [CW:0]   fold1;
      logic [CW:0]   fold2;
      sum = {3'b000, ~hc} + {3'b000, ~old_v[IW-1:CW]} + {3'b000, ~old_v[CW-1:0]}
          + {3'b000, new_v[IW-1:CW]} + {3'b000, new_v[CW-1:0]};
      fold1 = {1'b0, sum[CW-1:0]} + {{(CW-2){1'b0}}, sum[CW+2:CW]};
      fold2 = {1'b0, fold1[CW-1:0]} + {{CW{1'b0}}, fold1[CW]};
      return ~fold2[CW-1:0];
   endfunction

   // configuration
   logic [mkunr_pkg::MacWidth-1:0] zero_mac_ff, one_mac_ff;
   logic [IW-1:0]                  zero_ip_ff, one_ip_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_mac_ff <= mkunr_pkg::ENTRY_ZERO_MAC_RESET;
         zero_ip_ff  <= mkunr_pkg::ENTRY_ZERO_NEW_IP_RESET;
         one_mac_ff  <= mkunr_pkg::ENTRY_ONE_MAC_RESET;
         one_ip_ff   <= mkunr_pkg::ENTRY_ONE_NEW_IP_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            mkunr_pkg::CSR_ENTRY_ZERO_MAC:    zero_mac_ff <= csr_write_data;
            mkunr_pkg::CSR_ENTRY_ZERO_NEW_IP: zero_ip_ff  <= csr_write_data[IW-1:0];
            mkunr_pkg::CSR_ENTRY_ONE_MAC:     one_mac_ff  <= csr_write_data;
            mkunr_pkg::CSR_ENTRY_ONE_NEW_IP:  one_ip_ff   <= csr_write_data[IW-1:0];
            default: ;
         endcase
      end
   end

   // captured word
   logic                               op_ff;
   logic [mkunr_pkg::MacWidth-1:0]     mac_ff;
   logic [mkunr_pkg::ProtoWidth-1:0]   proto_ff;
   logic [IW-1:0]                      sip_ff, sip_in, dip_ff, dip_in;
   logic [CW-1:0]                      ipc_ff, udc_ff;
   logic                               hit_ff, hit_in;
   logic [IW-1:0]                      old_ff, old_in, new_ff, new_in;
   logic [IW-1:0]                      saved_ff [2];
   logic [IW-1:0]                      saved_in [2];

   logic is_udp, mac_one, mac_zero, ip_one, ip_zero;

   always_comb begin
      is_udp   = (proto_ff == mkunr_pkg::UDP_PROTOCOL);
      mac_one  = (mac_ff == one_mac_ff);
      mac_zero = (mac_ff == zero_mac_ff);
      ip_one   = (dip_ff == one_ip_ff);
      ip_zero  = (dip_ff == zero_ip_ff);
      hit_in   = 1'b0;
      old_in   = '0;
      new_in   = '0;
      sip_in   = sip_ff;
      dip_in   = dip_ff;
      saved_in = saved_ff;
      if (is_udp) begin
         if (op_ff == mkunr_pkg::OP_INBOUND) begin
            if (mac_one || mac_zero) begin
               hit_in = 1'b1;
               old_in = sip_ff;
               new_in = mac_one ? one_ip_ff : zero_ip_ff;
               sip_in = new_in;
               if (mac_one) saved_in[1] = sip_ff;
               else         saved_in[0] = sip_ff;
            end
         end else begin
            if (ip_one || ip_zero) begin
               hit_in = 1'b1;
               old_in = dip_ff;
               new_in = ip_one ? saved_ff[1] : saved_ff[0];
               dip_in = new_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         saved_ff[0] <= '0;
         saved_ff[1] <= '0;
      end else if (cmd.lookup) begin
         saved_ff <= saved_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_operation;
         mac_ff   <= req_source_mac;
         proto_ff <= req_protocol;
         sip_ff   <= req_src_ip;
         dip_ff   <= req_dst_ip;
         ipc_ff   <= req_ip_checksum;
         udc_ff   <= req_udp_checksum;
      end else if (cmd.lookup) begin
         sip_ff <= sip_in;
         dip_ff <= dip_in;
         hit_ff <= hit_in;
         old_ff <= old_in;
         new_ff <= new_in;
      end
   end

   // checksum update and output word
   logic [CW-1:0] ipc_new, udc_adj, udc_new;
   logic          final_new;

   always_comb begin
      ipc_new   = ipc_ff;
      udc_new   = udc_ff;
      final_new = 1'b0;
      udc_adj   = adjust(udc_ff, old_ff, new_ff);
      if (hit_ff) begin
         ipc_new = adjust(ipc_ff, old_ff, new_ff);
         if (udc_ff != '0) begin
            // zero on the wire means no checksum
            udc_new   = (udc_adj == '0) ? {CW{1'b1}} : udc_adj;
            final_new = (op_ff == mkunr_pkg::OP_OUTBOUND);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_matched          <= hit_ff;
         rsp_src_ip_out       <= sip_ff;
         rsp_dst_ip_out       <= dip_ff;
         rsp_ip_checksum_out  <= ipc_new;
         rsp_udp_checksum_out <= udc_new;
         rsp_checksum_final   <= final_new;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/mac_keyed_udp_nat_rewrite_core.sv
`default_nettype none
// Static NAT for UDP keyed by source MAC, with incremental checksum update.
// Input channel (req_*): one packet header word per handshake, accepted when
// req_valid is high and req_stall is low. Result channel (rsp_*): one word
// per input word, taken when rsp_valid is high and rsp_stall is low.
// Configuration (csr_*): a write with csr_write_enable sets the table entry
// MACs and new addresses; write only while the block is idle.
// An accepted word is captured, goes through the lookup register, then the
// checksum update into the output register.
// The controller walks each word through the lookup and the checksum adder
// before taking the next one.
// The output register frees the input side: a new word is taken while a result
// still waits, and a stalled result holds its value until taken; the next
// result then waits in the checksum stage.
// Reset (synchronous, active high) restores the default table entries, clears
// the saved original source addresses to zero and empties the pipeline.
module mac_keyed_udp_nat_rewrite_core (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   csr_write_enable,
   input  wire  [mkunr_pkg::CsrIdxWidth-1:0]     csr_index,
   input  wire  [mkunr_pkg::MacWidth-1:0]        csr_write_data,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire                                   req_operation,
   input  wire  [mkunr_pkg::MacWidth-1:0]        req_source_mac,
   input  wire  [mkunr_pkg::ProtoWidth-1:0]      req_protocol,
   input  wire  [mkunr_pkg::IpWidth-1:0]         req_src_ip,
   input  wire  [mkunr_pkg::IpWidth-1:0]         req_dst_ip,
   input  wire  [mkunr_pkg::CsumWidth-1:0]       req_ip_checksum,
   input  wire  [mkunr_pkg::CsumWidth-1:0]       req_udp_checksum,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic                                  rsp_matched,
   output logic [mkunr_pkg::IpWidth-1:0]         rsp_src_ip_out,
   output logic [mkunr_pkg::IpWidth-1:0]         rsp_dst_ip_out,
   output logic [mkunr_pkg::CsumWidth-1:0]       rsp_ip_checksum_out,
   output logic [mkunr_pkg::CsumWidth-1:0]       rsp_udp_checksum_out,
   output logic                                  rsp_checksum_final
);

   mkunr_pkg::cmd_type cmd;

   mkunr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   mkunr_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_operation        (req_operation),
      .req_source_mac       (req_source_mac),
      .req_protocol         (req_protocol),
      .req_src_ip           (req_src_ip),
      .req_dst_ip           (req_dst_ip),
      .req_ip_checksum      (req_ip_checksum),
      .req_udp_checksum     (req_udp_checksum),
      .rsp_matched          (rsp_matched),
      .rsp_src_ip_out       (rsp_src_ip_out),
      .rsp_dst_ip_out       (rsp_dst_ip_out),
      .rsp_ip_checksum_out  (rsp_ip_checksum_out),
      .rsp_udp_checksum_out (rsp_udp_checksum_out),
      .rsp_checksum_final   (rsp_checksum_final)
   );

endmodule
`default_nettype wire
